FILE: rtl/mtsm_pkg.sv
// mtsm_pkg: shared types, action codes and the mix clamp for the sample mixer
// used by multi_track_sample_mixer_core
`timescale 1ns / 1ps

package mtsm_pkg;

	// input action codes
	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_WRITE = 3'd1,
		ACT_LOAD  = 3'd2,
		ACT_PLAY  = 3'd3,
		ACT_STOP  = 3'd4,
		ACT_PAUSE = 3'd5
	} action_t;

	// sequencer states, one-hot
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_MIX  = 2'b10
	} state_t;

	localparam logic signed [8:0] SAMPLE_MAX = 9'sd127;
	localparam logic signed [8:0] SAMPLE_MIN = -9'sd128;

	// clamp a widened running sum back to the sample range
	function automatic logic signed [7:0] clamp_sample(input logic signed [8:0] val);
		logic signed [7:0] res;
		if (val > SAMPLE_MAX) begin
			res = 8'sd127;
		end else if (val < SAMPLE_MIN) begin
			res = -8'sd128;
		end else begin
			res = val[7:0];
		end
		return res;
	endfunction

endpackage

FILE: rtl/multi_track_sample_mixer_core.sv
// multi_track_sample_mixer_core: eight-track sample playback mixer
// Tick: busy while the sequencer walks the tracks in S_MIX; the result strobe comes
// as the walk ends and busy drops; the sample memory read port visits one track per cycle.
// Other actions: result strobe on the next cycle, busy stays low, one per cycle.
// The receiver cannot stall: each result is shown for one cycle with done high.
// Reset clears heads, lengths and flags; the sample memory is not cleared.
`timescale 1ns / 1ps

module multi_track_sample_mixer_core #(
	parameter int TRACKS      = 8,
	parameter int TRACK_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic [2:0]         track,
	input  logic [11:0]        sample_address,
	input  logic signed [7:0]  sample_value,
	input  logic [12:0]        length_value,
	input  logic               loop_enable,
	output logic               done,
	output logic signed [7:0]  mixed_sample,
	output logic [7:0]         playing_mask
);

	import mtsm_pkg::*;

	localparam int PW        = $clog2(TRACK_DEPTH);
	localparam int SW        = $clog2(TRACK_DEPTH + 1);
	localparam int TW        = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int CW        = $clog2(TRACKS + 1);
	localparam int AW        = TW + PW;
	localparam int MEM_DEPTH = TRACKS * (2 ** PW);

	// track state
	logic [PW-1:0] rpos_q [TRACKS];
	logic [SW-1:0] size_q [TRACKS];
	logic          play_q [TRACKS];
	logic          loop_q [TRACKS];

	state_t state_q;
	logic [CW-1:0] idx_q;
	logic signed [7:0] sum_q;
	logic done_q;
	logic signed [7:0] mix_q;

	// stage 1 of the mix walk
	logic              valid_s1;
	logic [TW-1:0]     trk_s1;
	logic [PW-1:0]     pos_s1;
	logic [SW-1:0]     size_s1;
	logic              loop_s1;
	logic              act_s1;
	logic              zero_s1;

	logic accept;
	logic valid_trk;
	logic [4:0] trk_ext;
	logic [TW-1:0] trk_idx;
	logic [15:0] addr_ext;
	logic addr_ok;
	logic [16:0] len_ext;
	logic [SW-1:0] len_sat;

	logic issue;
	logic finish;
	logic [TW-1:0] cur;
	logic [PW-1:0] pos_eff;
	logic [SW-1:0] pos_next;
	logic wrap;
	logic signed [7:0] sum_next;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic signed [7:0] ram_rdata;

	// input decode
	assign accept    = start & ~busy;
	assign trk_ext   = 5'(track);
	assign trk_idx   = trk_ext[TW-1:0];
	assign valid_trk = (32'(track) < TRACKS);
	assign addr_ext  = 16'(sample_address);
	assign addr_ok   = (32'(sample_address) < TRACK_DEPTH);
	assign len_ext   = 17'(length_value);
	assign len_sat   = (32'(length_value) > TRACK_DEPTH) ? SW'(TRACK_DEPTH) : len_ext[SW-1:0];

	// stage 0: pick the track under the walk and its effective head
	assign issue  = (state_q == S_MIX) && (idx_q < CW'(TRACKS));
	assign finish = (state_q == S_MIX) && !issue;
	assign cur    = idx_q[TW-1:0];
	assign pos_eff = (SW'(rpos_q[cur]) >= size_q[cur]) ? '0 : rpos_q[cur];

	// stage 1: accumulate and advance the head
	assign pos_next = SW'(pos_s1) + SW'(1);
	assign wrap     = (pos_next >= size_s1);
	assign sum_next = (valid_s1 && act_s1) ?
		clamp_sample(9'(sum_q) + 9'(ram_rdata)) : sum_q;

	// sample memory ports
	assign ram_we    = accept && (action == ACT_WRITE) && valid_trk && addr_ok;
	assign ram_waddr = {trk_idx, addr_ext[PW-1:0]};
	assign ram_raddr = {cur, pos_eff};

	mtsm_sample_ram #(
		.AW    (AW),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sample_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_TICK) begin
							state_q <= S_MIX;
							idx_q   <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_MIX: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// stage 1 payload, running sum and result value
	always_ff @(posedge clk) begin
		trk_s1  <= cur;
		pos_s1  <= pos_eff;
		size_s1 <= size_q[cur];
		loop_s1 <= loop_q[cur];
		act_s1  <= play_q[cur] && (size_q[cur] != '0);
		zero_s1 <= play_q[cur] && (size_q[cur] == '0);
		if (accept) begin
			sum_q <= '0;
			mix_q <= '0;
		end else begin
			sum_q <= sum_next;
			if (finish) begin
				mix_q <= sum_next;
			end
		end
	end

	// per-track state: host actions while idle, head updates during the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				rpos_q[i] <= '0;
				size_q[i] <= '0;
				play_q[i] <= 1'b0;
				loop_q[i] <= 1'b0;
			end
		end else if (accept && valid_trk) begin
			case (action)
				ACT_LOAD: begin
					size_q[trk_idx] <= len_sat;
					rpos_q[trk_idx] <= '0;
				end
				ACT_PLAY: begin
					play_q[trk_idx] <= 1'b1;
					loop_q[trk_idx] <= loop_enable;
				end
				ACT_STOP: begin
					play_q[trk_idx] <= 1'b0;
					rpos_q[trk_idx] <= '0;
				end
				ACT_PAUSE: begin
					play_q[trk_idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (valid_s1) begin
			if (zero_s1) begin
				play_q[trk_s1] <= 1'b0;
				rpos_q[trk_s1] <= '0;
			end else if (act_s1) begin
				if (wrap) begin
					rpos_q[trk_s1] <= '0;
					if (!loop_s1) begin
						play_q[trk_s1] <= 1'b0;
					end
				end else begin
					rpos_q[trk_s1] <= pos_next[PW-1:0];
				end
			end
		end
	end

	// playing mask for the first eight tracks
	always_comb begin
		playing_mask = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < TRACKS) begin
				playing_mask[i] = play_q[i];
			end
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign mixed_sample = mix_q;

endmodule

FILE: rtl/mtsm_sample_ram.sv
// mtsm_sample_ram: sample memory for all tracks, one write and one read port
// read data is registered; contents are not cleared by reset
`timescale 1ns / 1ps

module mtsm_sample_ram #(
	parameter int AW    = 15,
	parameter int DEPTH = 32768
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [7:0]    wdata,
	input  logic [AW-1:0]        raddr,
	output logic signed [7:0]    rdata
);

	logic signed [7:0] mem [DEPTH];
	logic signed [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
